[hw/rtl/kcl_pkg.sv]
package kcl_pkg;

  // Field and register widths
  localparam int unsigned KEY_W       = 4;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned CODE_W      = 24;
  localparam int unsigned HOLD_W      = 8;
  localparam int unsigned SHOWN_W     = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned PACK_W      = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FACTORY_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SECONDS = 1'd1;

  // Register reset values
  localparam logic [CODE_W-1:0] FACTORY_RESET = 24'h888888;
  localparam logic [HOLD_W-1:0] HOLD_RESET    = 8'd5;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_DELETE    = 4'd13;
  localparam logic [KEY_W-1:0] KEY_CHANGE    = 4'd14;
  localparam logic [KEY_W-1:0] KEY_START     = 4'd15;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    PHASE_IDLE  = 2'd0,
    PHASE_OPEN  = 2'd1,
    PHASE_ERROR = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    GOOD_NONE = 2'd0,
    GOOD_YES  = 2'd1,
    GOOD_NO   = 2'd2
  } good_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_OPENED   = 2'd1,
    EV_REJECTED = 2'd2,
    EV_IDLE     = 2'd3
  } event_e;

  typedef struct packed {
    cmd_e             command;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic               motor_on;
    logic               entry_lamp;
    logic               change_lamp;
    logic               error_lamp;
    logic [SHOWN_W-1:0] digits_entered;
    event_e             event_res;
    logic               code_saved;
    logic [CODE_W-1:0]  saved_code;
  } out_t;

  // Pick one digit of a packed code, place counted from the least significant nibble
  function automatic logic [DIGIT_W-1:0] code_digit(logic [CODE_W-1:0] code,
                                                    int unsigned place);
    logic [PACK_W-1:0] wide;
    wide = PACK_W'(code) >> (DIGIT_W * place);
    return wide[DIGIT_W-1:0];
  endfunction

endpackage

[hw/rtl/keypad_combination_lock.sv]
// A result is registered in the cycle after its item is transferred.
// Throughput: one item per cycle unless stalled; every item is handled in a single
// pass from the lock state registers through the digit compare into the result
// register. in_stall_o rises only while a result waits and out_stall_i is high.
// Reset clears all control state and loads the stored code from the factory default.
module keypad_combination_lock #(
  parameter int unsigned CODE_DIGITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  kcl_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output kcl_pkg::out_t                    out_data_o
);

  localparam int unsigned IDX_W = $clog2(CODE_DIGITS);
  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CODE_DIGITS);

  logic                              in_accept;
  logic [kcl_pkg::HOLD_W-1:0]        hold_q;

  logic                              entry_q, entry_d;
  logic                              change_q, change_d;
  logic [CNT_W-1:0]                  pos_q, pos_d;
  logic [kcl_pkg::DIGIT_W-1:0]       entered_q [CODE_DIGITS];
  logic [kcl_pkg::DIGIT_W-1:0]       entered_d [CODE_DIGITS];
  logic [kcl_pkg::DIGIT_W-1:0]       stored_q [CODE_DIGITS];
  logic [kcl_pkg::DIGIT_W-1:0]       stored_d [CODE_DIGITS];
  kcl_pkg::phase_e                   phase_q, phase_d;
  logic                              timer_q, timer_d;
  logic [kcl_pkg::HOLD_W-1:0]        secs_q, secs_d;
  kcl_pkg::good_e                    good_q, good_d;
  logic                              motor_q, motor_d;
  logic                              error_q, error_d;

  logic                              match;
  kcl_pkg::event_e                   ev;
  logic                              saved;
  logic [kcl_pkg::PACK_W-1:0]        pack_v;

  kcl_pkg::out_t                     result;
  kcl_pkg::out_t                     out_q;
  logic                              out_valid_q, out_valid_d;

  // Stall only while a finished result is held back
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next lock state for the item on the input
  always_comb begin
    entry_d  = entry_q;
    change_d = change_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    timer_d  = timer_q;
    secs_d   = secs_q;
    good_d   = good_q;
    motor_d  = motor_q;
    error_d  = error_q;
    ev       = kcl_pkg::EV_NONE;
    saved    = 1'b0;
    match    = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      entered_d[i] = entered_q[i];
      stored_d[i]  = stored_q[i];
    end

    if (in_data_i.command == kcl_pkg::CMD_TICK) begin
      if (timer_q) begin
        secs_d = secs_q + 8'd1;
      end
    end else if (in_data_i.key <= kcl_pkg::KEY_DIGIT_MAX) begin
      if (pos_d >= LAST_CNT) begin
        pos_d = '0;
      end
      // Fill the entry and compare once the last digit is in
      if (entry_q) begin
        entered_d[pos_d[IDX_W-1:0]] = in_data_i.key;
        pos_d = pos_d + 1'b1;
        if (pos_d >= LAST_CNT) begin
          pos_d   = '0;
          entry_d = 1'b0;
          for (int i = 0; i < CODE_DIGITS; i++) begin
            if (entered_d[i] != stored_d[i]) begin
              match = 1'b0;
            end
          end
          timer_d = 1'b1;
          if (match) begin
            good_d  = kcl_pkg::GOOD_YES;
            motor_d = 1'b1;
            phase_d = kcl_pkg::PHASE_OPEN;
            ev      = kcl_pkg::EV_OPENED;
          end else begin
            good_d  = kcl_pkg::GOOD_NO;
            error_d = 1'b1;
            phase_d = kcl_pkg::PHASE_ERROR;
            ev      = kcl_pkg::EV_REJECTED;
          end
        end
      end
      // Replace the stored code digit by digit
      if (change_q) begin
        stored_d[pos_d[IDX_W-1:0]] = in_data_i.key;
        pos_d = pos_d + 1'b1;
        if (pos_d >= LAST_CNT) begin
          pos_d    = '0;
          change_d = 1'b0;
          saved    = 1'b1;
          phase_d  = kcl_pkg::PHASE_OPEN;
          timer_d  = 1'b1;
          motor_d  = 1'b1;
        end
      end
    end else if (in_data_i.key == kcl_pkg::KEY_DELETE) begin
      if (entry_q) begin
        timer_d  = 1'b0;
        secs_d   = '0;
        entry_d  = 1'b1;
        change_d = 1'b0;
        pos_d    = '0;
      end
      if (change_d) begin
        for (int i = 0; i < CODE_DIGITS; i++) begin
          stored_d[i] = '0;
        end
        pos_d = '0;
      end
    end else if (in_data_i.key == kcl_pkg::KEY_CHANGE) begin
      if (good_q == kcl_pkg::GOOD_YES) begin
        good_d   = kcl_pkg::GOOD_NONE;
        change_d = 1'b1;
        entry_d  = 1'b0;
        phase_d  = kcl_pkg::PHASE_IDLE;
        timer_d  = 1'b0;
        secs_d   = '0;
      end
    end else if (in_data_i.key == kcl_pkg::KEY_START) begin
      timer_d  = 1'b0;
      secs_d   = '0;
      entry_d  = 1'b1;
      change_d = 1'b0;
    end

    // Return to idle once the hold time has run out
    if ((phase_d != kcl_pkg::PHASE_IDLE) && (secs_d >= hold_q)) begin
      timer_d  = 1'b0;
      secs_d   = '0;
      motor_d  = 1'b0;
      error_d  = 1'b0;
      phase_d  = kcl_pkg::PHASE_IDLE;
      entry_d  = 1'b0;
      change_d = 1'b0;
      pos_d    = '0;
      ev       = kcl_pkg::EV_IDLE;
    end
  end

  // Build the result from the new state
  always_comb begin
    pack_v = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      pack_v = {pack_v[kcl_pkg::PACK_W-kcl_pkg::DIGIT_W-1:0], stored_d[i]};
    end
    result.motor_on       = motor_d;
    result.entry_lamp     = entry_d;
    result.change_lamp    = change_d;
    result.error_lamp     = error_d;
    result.digits_entered = kcl_pkg::SHOWN_W'(pos_d);
    result.event_res      = ev;
    result.code_saved     = saved;
    result.saved_code     = pack_v[kcl_pkg::CODE_W-1:0];
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= kcl_pkg::HOLD_RESET;
      entry_q     <= 1'b0;
      change_q    <= 1'b0;
      pos_q       <= '0;
      phase_q     <= kcl_pkg::PHASE_IDLE;
      timer_q     <= 1'b0;
      secs_q      <= '0;
      good_q      <= kcl_pkg::GOOD_NONE;
      motor_q     <= 1'b0;
      error_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_q[i] <= kcl_pkg::code_digit(kcl_pkg::FACTORY_RESET, CODE_DIGITS - 1 - i);
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_index_i == kcl_pkg::CFG_HOLD_SECONDS) begin
        hold_q <= cfg_data_i[kcl_pkg::HOLD_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == kcl_pkg::CFG_FACTORY_CODE) begin
        for (int i = 0; i < CODE_DIGITS; i++) begin
          stored_q[i] <= kcl_pkg::code_digit(cfg_data_i[kcl_pkg::CODE_W-1:0],
                                             CODE_DIGITS - 1 - i);
        end
      end else if (in_accept) begin
        for (int i = 0; i < CODE_DIGITS; i++) begin
          stored_q[i] <= stored_d[i];
        end
      end
      if (in_accept) begin
        entry_q  <= entry_d;
        change_q <= change_d;
        pos_q    <= pos_d;
        phase_q  <= phase_d;
        timer_q  <= timer_d;
        secs_q   <= secs_d;
        good_q   <= good_d;
        motor_q  <= motor_d;
        error_q  <= error_d;
      end
    end
  end

  // Entry digits and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= result;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        entered_q[i] <= entered_d[i];
      end
    end
  end

  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(entry_q && change_q))
    else $error("entry and change modes active together");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < LAST_CNT)
    else $error("digit position out of range");

  a_timer_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !timer_q |-> (secs_q == '0))
    else $error("second count nonzero while timer stopped");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("transfer did not produce a result");

  a_open_drives_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_res == kcl_pkg::EV_OPENED) |-> out_q.motor_on)
    else $error("opened event without motor");

endmodule

[verif/keypad_combination_lock_test.sv]
module keypad_combination_lock_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDIG           = 6;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int CW             = kcl_pkg::CODE_W;
  localparam int IN_W           = $bits(kcl_pkg::in_t);
  localparam logic [kcl_pkg::KEY_W-1:0] KEY_SPARE_LO = 4'd10;
  localparam logic [kcl_pkg::KEY_W-1:0] KEY_SPARE_HI = 4'd12;

  // Tracks the lock state and holds every output field each transfer should produce
  class lock_scoreboard;
    logic [kcl_pkg::CODE_W-1:0]  factory;
    logic [kcl_pkg::HOLD_W-1:0]  hold;
    bit                          entry_on, change_on, timer_on, motor, err;
    logic [kcl_pkg::SHOWN_W-1:0] pos;
    logic [kcl_pkg::DIGIT_W-1:0] entered [NDIG];
    logic [kcl_pkg::DIGIT_W-1:0] stored [NDIG];
    kcl_pkg::phase_e             phase;
    kcl_pkg::good_e              last_good;
    logic [kcl_pkg::HOLD_W-1:0]  secs;
    kcl_pkg::out_t               lock_outputs_q [$];
    int errors, accepted, checked, opened, rejected, timeouts, saves;

    function new();
      errors = 0;
      accepted = 0;
      checked = 0;
      opened = 0;
      rejected = 0;
      timeouts = 0;
      saves = 0;
      factory = kcl_pkg::FACTORY_RESET;
      hold = kcl_pkg::HOLD_RESET;
      entry_on = 0;
      change_on = 0;
      timer_on = 0;
      motor = 0;
      err = 0;
      pos = '0;
      phase = kcl_pkg::PHASE_IDLE;
      last_good = kcl_pkg::GOOD_NONE;
      secs = '0;
      foreach (entered[i]) entered[i] = '0;
      load_factory();
    endfunction

    // Digit 0 sits in the most significant nibble
    function void load_factory();
      for (int i = 0; i < NDIG; i++) begin
        stored[i] = factory[kcl_pkg::DIGIT_W*(NDIG-1-i) +: kcl_pkg::DIGIT_W];
      end
    endfunction

    function logic [kcl_pkg::CODE_W-1:0] stored_code();
      logic [kcl_pkg::CODE_W-1:0] c;
      c = '0;
      for (int i = 0; i < NDIG; i++) begin
        c = {c[kcl_pkg::CODE_W-kcl_pkg::DIGIT_W-1:0], stored[i]};
      end
      return c;
    endfunction

    function void set_reg(logic [kcl_pkg::CFG_IDX_W-1:0] idx,
                          logic [kcl_pkg::CFG_DATA_W-1:0] d);
      if (idx == kcl_pkg::CFG_FACTORY_CODE) begin
        factory = d[kcl_pkg::CODE_W-1:0];
        load_factory();
      end else begin
        hold = d[kcl_pkg::HOLD_W-1:0];
      end
    endfunction

    function int pending();
      return lock_outputs_q.size();
    endfunction

    function void begin_entry();
      timer_on = 0;
      secs = '0;
      entry_on = 1;
      change_on = 0;
    endfunction

    // Advance the lock by one accepted transfer and queue the outputs it causes
    function void note_input(kcl_pkg::in_t it);
      kcl_pkg::event_e ev;
      bit              saved;
      bit              same;
      kcl_pkg::out_t   r;
      ev = kcl_pkg::EV_NONE;
      saved = 0;
      if (it.command == kcl_pkg::CMD_TICK) begin
        if (timer_on) secs = secs + 1'b1;
      end else if (it.key <= kcl_pkg::KEY_DIGIT_MAX) begin
        if (pos >= NDIG) pos = '0;
        if (entry_on) begin
          entered[pos] = it.key;
          pos = pos + 1'b1;
          if (pos >= NDIG) begin
            pos = '0;
            entry_on = 0;
            same = 1;
            for (int i = 0; i < NDIG; i++) if (entered[i] != stored[i]) same = 0;
            timer_on = 1;
            if (same) begin
              last_good = kcl_pkg::GOOD_YES;
              motor = 1;
              phase = kcl_pkg::PHASE_OPEN;
              ev = kcl_pkg::EV_OPENED;
            end else begin
              last_good = kcl_pkg::GOOD_NO;
              err = 1;
              phase = kcl_pkg::PHASE_ERROR;
              ev = kcl_pkg::EV_REJECTED;
            end
          end
        end
        if (change_on) begin
          stored[pos] = it.key;
          pos = pos + 1'b1;
          if (pos >= NDIG) begin
            pos = '0;
            change_on = 0;
            saved = 1;
            phase = kcl_pkg::PHASE_OPEN;
            timer_on = 1;
            motor = 1;
          end
        end
      end else if (it.key == kcl_pkg::KEY_DELETE) begin
        if (entry_on) begin
          begin_entry();
          pos = '0;
        end
        if (change_on) begin
          foreach (stored[i]) stored[i] = '0;
          pos = '0;
        end
      end else if (it.key == kcl_pkg::KEY_CHANGE) begin
        if (last_good == kcl_pkg::GOOD_YES) begin
          last_good = kcl_pkg::GOOD_NONE;
          change_on = 1;
          entry_on = 0;
          phase = kcl_pkg::PHASE_IDLE;
          timer_on = 0;
          secs = '0;
        end
      end else if (it.key == kcl_pkg::KEY_START) begin
        begin_entry();
      end

      // Hold time over: close and drop back to idle
      if (phase != kcl_pkg::PHASE_IDLE && secs >= hold) begin
        timer_on = 0;
        secs = '0;
        motor = 0;
        err = 0;
        phase = kcl_pkg::PHASE_IDLE;
        entry_on = 0;
        change_on = 0;
        pos = '0;
        ev = kcl_pkg::EV_IDLE;
      end

      case (ev)
        kcl_pkg::EV_OPENED:   opened++;
        kcl_pkg::EV_REJECTED: rejected++;
        kcl_pkg::EV_IDLE:     timeouts++;
        default: ;
      endcase
      if (saved) saves++;

      r.motor_on = motor;
      r.entry_lamp = entry_on;
      r.change_lamp = change_on;
      r.error_lamp = err;
      r.digits_entered = pos;
      r.event_res = ev;
      r.code_saved = saved;
      r.saved_code = stored_code();
      lock_outputs_q.push_back(r);
      accepted++;
    endfunction

    function void compare_field(string name, logic [kcl_pkg::CODE_W-1:0] want,
                                logic [kcl_pkg::CODE_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(kcl_pkg::out_t got);
      kcl_pkg::out_t want;
      if (lock_outputs_q.size() == 0) begin
        errors++;
        $display("%0t: result %0h with none expected, expected nothing, actual %0h",
                 $time, got, got);
        return;
      end
      want = lock_outputs_q.pop_front();
      checked++;
      compare_field("motor_on", CW'(want.motor_on), CW'(got.motor_on));
      compare_field("entry_lamp", CW'(want.entry_lamp), CW'(got.entry_lamp));
      compare_field("change_lamp", CW'(want.change_lamp), CW'(got.change_lamp));
      compare_field("error_lamp", CW'(want.error_lamp), CW'(got.error_lamp));
      compare_field("digits_entered", CW'(want.digits_entered), CW'(got.digits_entered));
      compare_field("event_res", CW'(want.event_res), CW'(got.event_res));
      compare_field("code_saved", CW'(want.code_saved), CW'(got.code_saved));
      compare_field("saved_code", want.saved_code, got.saved_code);
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index_i = kcl_pkg::CFG_FACTORY_CODE;
  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  kcl_pkg::in_t                   in_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  kcl_pkg::out_t                  out_data_o;

  int in_idle_pct = 15;
  int rx_idle_pct = 15;
  int holdoff_reqs = 0;
  int holdoff_done = 0;
  int holdoff_left = 0;

  lock_scoreboard sb;

  keypad_combination_lock #(
    .CODE_DIGITS(NDIG)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Check each output transfer, then pick the next stall: a requested hold-off or random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (holdoff_reqs != holdoff_done) begin
      holdoff_done++;
      holdoff_left = HOLDOFF_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offer one item, with a random gap first, and hold it until the transfer
  task automatic send_item(input kcl_pkg::in_t it);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic press(input logic [kcl_pkg::KEY_W-1:0] k);
    kcl_pkg::in_t it;
    it.command = kcl_pkg::CMD_KEY;
    it.key = k;
    send_item(it);
  endtask

  // Key field is a don't-care on a tick, so randomize it
  task automatic tick();
    kcl_pkg::in_t it;
    it.command = kcl_pkg::CMD_TICK;
    it.key = kcl_pkg::KEY_W'($urandom_range(15));
    send_item(it);
  endtask

  function automatic logic [kcl_pkg::KEY_W-1:0] rand_digit();
    return kcl_pkg::KEY_W'($urandom_range(kcl_pkg::KEY_DIGIT_MAX));
  endfunction

  // Stored digits above nine cannot be keyed in; substitute a random digit
  function automatic logic [kcl_pkg::KEY_W-1:0] code_key(
      input logic [kcl_pkg::DIGIT_W-1:0] dg);
    if (dg <= kcl_pkg::KEY_DIGIT_MAX) return dg;
    return rand_digit();
  endfunction

  // Drain all outstanding results, then write one register while the lock is quiet
  task automatic write_reg(input logic [kcl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kcl_pkg::CFG_DATA_W-1:0] d);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly complete entry and change sequences, with ticks and some noise mixed in
  task automatic random_phase(input int budget);
    int start;
    int kind;
    int wrong_at;
    kcl_pkg::in_t junk;
    start = sb.accepted;
    while (sb.accepted - start < budget) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        press(kcl_pkg::KEY_START);
        if (sb.pos != 0 || $urandom_range(9) == 0) press(kcl_pkg::KEY_DELETE);
        wrong_at = $urandom_range(1) ? -1 : $urandom_range(NDIG - 1);
        for (int i = 0; i < NDIG; i++) begin
          if ($urandom_range(29) == 0) press(kcl_pkg::KEY_START);
          if ($urandom_range(39) == 0) press(kcl_pkg::KEY_DELETE);
          press((i == wrong_at) ? rand_digit() : code_key(sb.stored[i]));
        end
        if (sb.last_good == kcl_pkg::GOOD_YES && $urandom_range(1)) begin
          press(kcl_pkg::KEY_CHANGE);
          for (int i = 0; i < NDIG; i++) begin
            if ($urandom_range(19) == 0) press(kcl_pkg::KEY_DELETE);
            press(rand_digit());
          end
        end
        if ($urandom_range(1)) begin
          while (sb.timer_on) tick();
        end else begin
          repeat ($urandom_range(2)) tick();
        end
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 4)) tick();
      end else if (kind < 85) begin
        press(kcl_pkg::KEY_W'($urandom_range(KEY_SPARE_LO, KEY_SPARE_HI)));
      end else begin
        junk = kcl_pkg::in_t'(IN_W'($urandom_range(31)));
        send_item(junk);
      end
    end
  endtask

  initial begin
    logic [kcl_pkg::CODE_W-1:0] code_val;
    logic [kcl_pkg::HOLD_W-1:0] hold_val;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle lock: tick and change key have no effect
    tick();
    press(kcl_pkg::KEY_CHANGE);
    // Restart mid-entry keeps the digit count; the factory code opens
    press(kcl_pkg::KEY_START);
    repeat (3) press(code_key(sb.stored[0]));
    press(kcl_pkg::KEY_START);
    repeat (3) press(code_key(sb.stored[0]));
    // Change mode, delete clears the stored code, then a full new code
    press(kcl_pkg::KEY_CHANGE);
    press(4'd0);
    press(kcl_pkg::KEY_DIGIT_MAX);
    press(kcl_pkg::KEY_DELETE);
    repeat (3) begin
      press(kcl_pkg::KEY_DIGIT_MAX);
      press(4'd0);
    end
    // Run out the hold time
    while (sb.timer_on) tick();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin code_val = 24'h000000; hold_val = 8'd1; end
        1: begin code_val = 24'hFFFFFF; hold_val = 8'd3; end
        2: begin code_val = kcl_pkg::CODE_W'($urandom); hold_val = 8'd255; end
        3: begin code_val = kcl_pkg::FACTORY_RESET; hold_val = 8'd2; end
        default: begin
          code_val = kcl_pkg::CODE_W'($urandom);
          hold_val = kcl_pkg::HOLD_W'($urandom_range(1, 6));
        end
      endcase
      write_reg(kcl_pkg::CFG_HOLD_SECONDS, kcl_pkg::CFG_DATA_W'(hold_val));
      write_reg(kcl_pkg::CFG_FACTORY_CODE, kcl_pkg::CFG_DATA_W'(code_val));
      in_idle_pct = (p == 4) ? 0 : 15;
      rx_idle_pct = (p == 4) ? 0 : 15;
      if (p == 5) holdoff_reqs++;
      random_phase(140);
    end

    // Drain and let the pipeline settle
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Run: %0d key/tick transfers in, %0d results checked, %0d errors",
             sb.accepted, sb.checked, sb.errors);
    $display("Seen: %0d opened, %0d rejected, %0d timeouts, %0d new codes saved",
             sb.opened, sb.rejected, sb.timeouts, sb.saves);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
